>>> design/b64ld_pkg.sv
// Shared constants, types and the character table of the base64 line decoder.
package b64ld_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] PH_NORMAL    = 2'd0;
    localparam logic [1:0] PH_CR_SEEN   = 2'd1;
    localparam logic [1:0] PH_DISCARD   = 2'd2;
    localparam logic [1:0] PH_AFTER_PAD = 2'd3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] LF_CHAR  = 8'h0A;
    localparam logic [7:0] CR_CHAR  = 8'h0D;
    localparam logic [7:0] NUL_CHAR = 8'h00;

    localparam logic [6:0] NO_SEXTET = 7'd127;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 4;
    localparam int SHOWN_BITS         = 16;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            data;
        logic [SHOWN_BITS-1:0] count;
    } result_t;

    // Up to three results caused by one character.
    typedef struct packed {
        logic [1:0]       n;
        result_t [2:0]    res;
    } job_t;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = NO_SEXTET;
        if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) v = 7'd62;
        else if (c == 8'h2F) v = 7'd63;
        return v;
    endfunction

endpackage

>>> design/b64ld_char_if.sv
// Handshake channel that carries one encoded character per word.
interface b64ld_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

>>> design/b64ld_result_if.sv
// Handshake channel that carries one decoded byte or status per word.
interface b64ld_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        last_of_item;

    modport source (output valid, output result_kind, output data_byte,
                    output byte_count, output last_of_item, input ready);
    modport sink (input valid, input result_kind, input data_byte,
                  input byte_count, input last_of_item, output ready);
endinterface

>>> design/base64_line_decoder.sv
// Top level of the strict base64 line decoder: front end, job queue and back end.
//
//   channel    direction  word contents
//   ---------  ---------  ----------------------------------------------------
//   chars      in         in_char: one encoded character
//   results    out        result_kind, data_byte, byte_count, last_of_item
//   cfg        in         cfg_write / cfg_data: terminator_mode (0 LF/CRLF, 1 NUL)
//
// The front end takes one character per cycle whenever the job queue has room and
// decides in that same cycle all results the character causes (zero to three).
// The back end drains one result word per cycle while the receiver is ready. A
// character that completes a full quad yields three words; the queue absorbs them.
// Reset clears the string state, the queue and the output stage at once; no
// clearing pass is needed. Either side may stall at any time without loss.
module base64_line_decoder
    import b64ld_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    b64ld_char_if.sink chars,
    b64ld_result_if.source results
);
    // Job handoff between the two halves.
    logic push;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic job_avail;
    job_t head_job;

    // The front end owns the terminator mode and all per-string state.
    b64ld_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .chars      (chars),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // A few jobs of slack let a stalled output leave the input running.
    b64ld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (job_avail),
        .head_job  (head_job)
    );

    // The back end serializes each job onto the registered output.
    b64ld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .head_job  (head_job),
        .pop       (pop),
        .results   (results)
    );

    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && queue_full))
        else $error("job pushed into a full queue");

    // Only jobs that carry results are queued.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (push_job.n != 2'd0))
        else $error("empty job queued");

    // A status word is always the only, and so the last, word of its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.result_kind != KIND_DATA) |->
            (results.last_of_item && results.data_byte == 8'd0))
        else $error("status word not last or carries data");

    // Result kinds stay within data, ok and error.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.result_kind == KIND_DATA ||
                           results.result_kind == KIND_OK ||
                           results.result_kind == KIND_ERR))
        else $error("bad result kind");

endmodule

>>> design/b64ld_queue.sv
// Short job queue between the character front end and the result back end.
module b64ld_queue
    import b64ld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);
    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> design/b64ld_front.sv
// Front end: accepts characters, tracks the quad and string state, builds result jobs.
module b64ld_front
    import b64ld_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic cfg_data,
    b64ld_char_if.sink chars,
    input  logic queue_full,
    output logic push,
    output job_t push_job
);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  mode_reg;
    logic [1:0]            quad_pos_reg, quad_pos_next;
    logic [17:0]           held_reg, held_next;
    logic                  third_pad_reg, third_pad_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  pad_mis_reg, pad_mis_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  accept;
    logic [7:0]            c;
    logic                  is_term, cr_ok, is_pad, sym_ok;
    logic [6:0]            v_raw;
    logic [5:0]            v;
    logic [COUNT_BITS-1:0] inc1, inc2, inc3;
    logic [7:0]            b1, b2, b3;
    logic                  do_finish;
    logic [1:0]            fin_kind, fin_phase;

    function automatic logic [SHOWN_BITS-1:0] shown(input logic [COUNT_BITS-1:0] cnt);
        logic [SHOWN_BITS-1:0] r;
        if ((COUNT_BITS > SHOWN_BITS) && (|(cnt >> SHOWN_BITS)))
            r = {SHOWN_BITS{1'b1}};
        else
            r = SHOWN_BITS'(cnt);
        return r;
    endfunction

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && !queue_full;
    assign c           = chars.in_char;
    assign is_term     = (c == (mode_reg ? NUL_CHAR : LF_CHAR));
    assign cr_ok       = !mode_reg && (c == CR_CHAR);
    assign is_pad      = (c == PAD_CHAR);
    assign v_raw       = sextet_of(c);
    assign sym_ok      = (v_raw != NO_SEXTET);
    assign v           = is_pad ? 6'd0 : v_raw[5:0];

    // Saturating counts after one, two and three more bytes.
    assign inc1 = (count_reg > COUNT_MAX - COUNT_BITS'(1)) ? COUNT_MAX : count_reg + COUNT_BITS'(1);
    assign inc2 = (count_reg > COUNT_MAX - COUNT_BITS'(2)) ? COUNT_MAX : count_reg + COUNT_BITS'(2);
    assign inc3 = (count_reg > COUNT_MAX - COUNT_BITS'(3)) ? COUNT_MAX : count_reg + COUNT_BITS'(3);

    assign b1 = {held_reg[17:12], held_reg[11:10]};
    assign b2 = {held_reg[9:6], held_reg[5:2]};
    assign b3 = {held_reg[1:0], v};

    always_comb
    begin
        quad_pos_next  = quad_pos_reg;
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        phase_next     = phase_reg;
        pad_mis_next   = pad_mis_reg;
        count_next     = count_reg;
        push_job       = '0;
        do_finish      = 1'b0;
        fin_kind       = KIND_OK;
        fin_phase      = PH_NORMAL;

        if (accept)
        begin
            case (phase_reg)
                PH_DISCARD:
                begin
                    if (is_term) phase_next = PH_NORMAL;
                end
                PH_CR_SEEN:
                begin
                    do_finish = 1'b1;
                    if (is_term)
                    begin
                        fin_kind = pad_mis_reg ? KIND_ERR : KIND_OK;
                    end
                    else
                    begin
                        fin_kind  = KIND_ERR;
                        fin_phase = PH_DISCARD;
                    end
                end
                PH_AFTER_PAD:
                begin
                    if (is_term)
                    begin
                        do_finish = 1'b1;
                        fin_kind  = pad_mis_reg ? KIND_ERR : KIND_OK;
                    end
                    else if (cr_ok)
                    begin
                        phase_next = PH_CR_SEEN;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_ERR;
                        fin_phase = PH_DISCARD;
                    end
                end
                default:
                begin
                    if (quad_pos_reg == 2'd0 && is_term)
                    begin
                        do_finish = 1'b1;
                    end
                    else if (quad_pos_reg == 2'd0 && cr_ok)
                    begin
                        phase_next = PH_CR_SEEN;
                    end
                    else if (!sym_ok && !(is_pad && quad_pos_reg >= 2'd2))
                    begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_ERR;
                        fin_phase = is_term ? PH_NORMAL : PH_DISCARD;
                    end
                    else if (quad_pos_reg != 2'd3)
                    begin
                        if (quad_pos_reg == 2'd2 && is_pad) third_pad_next = 1'b1;
                        held_next     = {held_reg[11:0], v};
                        quad_pos_next = quad_pos_reg + 2'd1;
                    end
                    else
                    begin
                        push_job.res[0] = '{kind: KIND_DATA, data: b1, count: shown(inc1)};
                        push_job.res[1] = '{kind: KIND_DATA, data: b2, count: shown(inc2)};
                        push_job.res[2] = '{kind: KIND_DATA, data: b3, count: shown(inc3)};
                        if (third_pad_reg)
                        begin
                            push_job.n   = 2'd1;
                            count_next   = inc1;
                            pad_mis_next = !is_pad;
                            phase_next   = PH_AFTER_PAD;
                        end
                        else if (is_pad)
                        begin
                            push_job.n = 2'd2;
                            count_next = inc2;
                            phase_next = PH_AFTER_PAD;
                        end
                        else
                        begin
                            push_job.n = 2'd3;
                            count_next = inc3;
                        end
                        quad_pos_next  = 2'd0;
                        held_next      = '0;
                        third_pad_next = 1'b0;
                    end
                end
            endcase

            if (do_finish)
            begin
                push_job.n      = 2'd1;
                push_job.res[0] = '{kind: fin_kind, data: 8'd0, count: shown(count_reg)};
                quad_pos_next   = 2'd0;
                held_next       = '0;
                third_pad_next  = 1'b0;
                pad_mis_next    = 1'b0;
                count_next      = '0;
                phase_next      = fin_phase;
            end
        end
    end

    assign push = (push_job.n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            quad_pos_reg  <= '0;
            held_reg      <= '0;
            third_pad_reg <= 1'b0;
            phase_reg     <= PH_NORMAL;
            pad_mis_reg   <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_write) mode_reg <= cfg_data;
            quad_pos_reg  <= quad_pos_next;
            held_reg      <= held_next;
            third_pad_reg <= third_pad_next;
            phase_reg     <= phase_next;
            pad_mis_reg   <= pad_mis_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> design/b64ld_back.sv
// Back end: unpacks queued jobs and presents their results one word at a time.
module b64ld_back
    import b64ld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_avail,
    input  job_t head_job,
    output logic pop,
    b64ld_result_if.source results
);
    logic       cur_valid_reg, cur_valid_next;
    job_t       cur_job_reg, cur_job_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg, out_res_next;
    logic       out_last_reg, out_last_next;

    logic advance, take, cur_last, cur_free;

    assign advance  = !out_valid_reg || results.ready;
    assign take     = advance && cur_valid_reg;
    assign cur_last = (idx_reg == cur_job_reg.n - 2'd1);
    assign cur_free = !cur_valid_reg || (take && cur_last);
    assign pop      = job_avail && cur_free;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;

        if (take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = cur_job_reg.res[idx_reg];
            out_last_next  = cur_last;
            idx_next       = idx_reg + 2'd1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_job_next   = head_job;
            idx_next       = 2'd0;
        end
        else if (take && cur_last)
        begin
            cur_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.result_kind  = out_res_reg.kind;
    assign results.data_byte    = out_res_reg.data;
    assign results.byte_count   = out_res_reg.count;
    assign results.last_of_item = out_last_reg;

endmodule

>>> bench/tb_base64_line_decoder.sv
// Self-checking testbench of the base64 line decoder with its own decode predictor.
module tb_base64_line_decoder;
    import b64ld_pkg::*;

    // The block decides all results of a character in the cycle it takes the
    // character, then drains them through a short job queue, one per cycle when ready.
    // A drain wait after the last result is enough to be sure it is idle.
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 55;
    localparam int PRESSURE_AT   = 60;
    localparam int PRESSURE_LEN  = 400;
    localparam int MAX_REPORTS   = 60;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One result word as the output channel shows it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] count;
        logic        last;
    } word_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_write;
    logic cfg_data;

    b64ld_char_if   chars_if ();
    b64ld_result_if results_if ();

    base64_line_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .chars     (chars_if),
        .results   (results_if)
    );

    // Characters waiting to be offered, and decoded words waiting to arrive.
    logic [7:0] pending_chars[$];
    word_t      expected_words[$];
    word_t      step_words[$];

    // Decoder state as the predictor tracks it.
    logic        nul_mode;
    logic [1:0]  quad_pos;
    logic [17:0] held;
    logic        third_pad;
    logic [1:0]  line_phase;
    logic        pad_bad;
    logic [15:0] line_count;

    // Character lookup, built from the alphabet at the start of the run.
    logic [5:0] sextet_val[256];
    logic       sextet_ok[256];

    int  fail_count   = 0;
    int  chars_taken  = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    int  pressure_left = 0;
    bit  pressure_done = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("FAIL base64_line_decoder");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Every so often both sides run flat out for a stretch of characters.
    function automatic bit calm_stretch();
        return (chars_taken % 100) >= 70;
    endfunction

    // ------------------------------------------------------------------
    // Predictor. Each accepted character is run through these routines and
    // the words it causes are appended to expected_words in order.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        if (line_count != COUNT_TOP)
        begin
            line_count = line_count + 16'd1;
        end
        step_words.push_back('{kind: KIND_DATA, data: b, count: line_count, last: 1'b0});
    endtask

    // A status word ends the string and clears everything but the mode.
    task automatic close_string(input logic [1:0] kind, input logic [1:0] next_phase);
        step_words.push_back('{kind: kind, data: 8'h00, count: line_count, last: 1'b0});
        quad_pos   = 2'd0;
        held       = 18'd0;
        third_pad  = 1'b0;
        pad_bad    = 1'b0;
        line_count = 16'd0;
        line_phase = next_phase;
    endtask

    task automatic decode_char(input logic [7:0] c);
        logic [7:0] term;
        logic       cr_here;
        logic       is_pad;
        logic       usable;
        logic [5:0] v;
        logic [5:0] s1;
        logic [5:0] s2;
        logic [5:0] s3;
        step_words.delete();
        term    = nul_mode ? NUL_CHAR : LF_CHAR;
        cr_here = !nul_mode && c == CR_CHAR;
        is_pad  = c == PAD_CHAR;
        v       = sextet_val[c];
        case (line_phase)
            PH_DISCARD:
            begin
                if (c == term)
                begin
                    line_phase = PH_NORMAL;
                end
            end
            PH_CR_SEEN:
            begin
                if (c == term)
                begin
                    close_string(pad_bad ? KIND_ERR : KIND_OK, PH_NORMAL);
                end
                else
                begin
                    close_string(KIND_ERR, PH_DISCARD);
                end
            end
            PH_AFTER_PAD:
            begin
                if (c == term)
                begin
                    close_string(pad_bad ? KIND_ERR : KIND_OK, PH_NORMAL);
                end
                else if (cr_here)
                begin
                    line_phase = PH_CR_SEEN;
                end
                else
                begin
                    close_string(KIND_ERR, PH_DISCARD);
                end
            end
            default:
            begin
                usable = sextet_ok[c] || (is_pad && quad_pos >= 2'd2);
                if (quad_pos == 2'd0 && c == term)
                begin
                    close_string(KIND_OK, PH_NORMAL);
                end
                else if (quad_pos == 2'd0 && cr_here)
                begin
                    line_phase = PH_CR_SEEN;
                end
                else if (!usable)
                begin
                    close_string(KIND_ERR, (c == term) ? PH_NORMAL : PH_DISCARD);
                end
                else
                begin
                    if (is_pad)
                    begin
                        v = 6'd0;
                    end
                    if (quad_pos != 2'd3)
                    begin
                        if (quad_pos == 2'd2 && is_pad)
                        begin
                            third_pad = 1'b1;
                        end
                        held     = {held[11:0], v};
                        quad_pos = quad_pos + 2'd1;
                    end
                    else
                    begin
                        s1 = held[17:12];
                        s2 = held[11:6];
                        s3 = held[5:0];
                        push_byte({s1, s2[5:4]});
                        if (third_pad)
                        begin
                            pad_bad    = !is_pad;
                            line_phase = PH_AFTER_PAD;
                        end
                        else
                        begin
                            push_byte({s2[3:0], s3[5:2]});
                            if (is_pad)
                            begin
                                line_phase = PH_AFTER_PAD;
                            end
                            else
                            begin
                                push_byte({s3[1:0], v});
                            end
                        end
                        quad_pos  = 2'd0;
                        held      = 18'd0;
                        third_pad = 1'b0;
                    end
                end
            end
        endcase
        if (step_words.size() > 0)
        begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
        foreach (step_words[i])
        begin
            expected_words.push_back(step_words[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. A character stays offered until it is taken; after each one a
    // random gap may follow before the next is offered.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid   <= 1'b0;
            chars_if.in_char <= 8'h00;
            send_gap         <= 0;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                decode_char(chars_if.in_char);
                chars_taken <= chars_taken + 1;
            end
            // Only move on when nothing is held up waiting for ready.
            if (!(chars_if.valid && !chars_if.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap       <= send_gap - 1;
                    chars_if.valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    chars_if.valid   <= 1'b1;
                    chars_if.in_char <= pending_chars.pop_front();
                    send_gap         <= calm_stretch() ? 0 : pick_gap();
                end
                else
                begin
                    chars_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each word taken is checked against the oldest expectation.
    // Ready drops at random, and once for a long stretch so that the job
    // queue fills and the block has to stall its character input.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected word, expected none, actual kind %0d data %0d",
                                 $time, results_if.result_kind, results_if.data_byte);
                    end
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("result_kind", want.kind, results_if.result_kind);
                    check_field("data_byte", want.data, results_if.data_byte);
                    check_field("byte_count", want.count, results_if.byte_count);
                    check_field("last_of_item", want.last, results_if.last_of_item);
                end
            end
            if (pressure_left > 0)
            begin
                pressure_left    <= pressure_left - 1;
                results_if.ready <= 1'b0;
            end
            else if (!pressure_done && chars_taken >= PRESSURE_AT)
            begin
                pressure_done    <= 1'b1;
                pressure_left    <= PRESSURE_LEN;
                results_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left       <= stall_left - 1;
                results_if.ready <= 1'b0;
            end
            else if (!calm_stretch() && $urandom_range(0, 3) == 0)
            begin
                stall_left       <= pick_gap();
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_b64();
        return ALPHABET[$urandom_range(0, 63)];
    endfunction

    task automatic queue_text(input string s);
        foreach (s[i])
        begin
            pending_chars.push_back(s[i]);
        end
    endtask

    // Wait until every character is taken and every word has arrived, then
    // give a character that caused no word time to leave the block.
    task automatic wait_drained();
        while (pending_chars.size() != 0 || chars_if.valid || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        nul_mode = m;
    endtask

    // One string: whole quads, maybe a padded tail, then the terminator of
    // the given mode. About one string in five is damaged on purpose.
    task automatic queue_random_string(input logic in_nul_mode, output int added);
        logic [7:0] line[$];
        int         quads;
        int         pos;
        quads = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 3);
        repeat (quads)
        begin
            repeat (4) line.push_back(random_b64());
        end
        case ($urandom_range(0, 4))
            1:
            begin
                line.push_back(random_b64());
                line.push_back(random_b64());
                line.push_back(PAD_CHAR);
                line.push_back(PAD_CHAR);
            end
            2:
            begin
                repeat (3) line.push_back(random_b64());
                line.push_back(PAD_CHAR);
            end
            3:
            begin
                // Third place padded but the fourth is not.
                line.push_back(random_b64());
                line.push_back(random_b64());
                line.push_back(PAD_CHAR);
                line.push_back(random_b64());
            end
            default:
            begin
            end
        endcase
        if (in_nul_mode)
        begin
            line.push_back(NUL_CHAR);
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                line.push_back(CR_CHAR);
            end
            line.push_back(LF_CHAR);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, line.size() - 1);
            if ($urandom_range(0, 2) == 0)
            begin
                line.insert(pos, 8'($urandom_range(0, 255)));
            end
            else
            begin
                line[pos] = 8'($urandom_range(0, 255));
            end
        end
        foreach (line[i])
        begin
            pending_chars.push_back(line[i]);
        end
        added = line.size();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int added;
        int queued;
        chars_if.valid   = 1'b0;
        chars_if.in_char = 8'h00;
        results_if.ready = 1'b0;
        cfg_write        = 1'b0;
        cfg_data         = 1'b0;

        foreach (sextet_ok[i])
        begin
            sextet_ok[i]  = 1'b0;
            sextet_val[i] = 6'd0;
        end
        for (int i = 0; i < 64; i++)
        begin
            sextet_ok[ALPHABET[i]]  = 1'b1;
            sextet_val[ALPHABET[i]] = 6'(i);
        end

        nul_mode   = 1'b0;
        quad_pos   = 2'd0;
        held       = 18'd0;
        third_pad  = 1'b0;
        line_phase = PH_NORMAL;
        pad_bad    = 1'b0;
        line_count = 16'd0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Line mode, directed. A full quad closed by CR LF at a quad start.
        write_mode(1'b0);
        queue_text("//+A");
        pending_chars.push_back(CR_CHAR);
        pending_chars.push_back(LF_CHAR);
        // An empty line.
        pending_chars.push_back(LF_CHAR);
        // Third place padded, fourth not: one byte, then an error status.
        queue_text("TQ=A");
        pending_chars.push_back(LF_CHAR);
        // A pad in the second place is invalid; the rest of the line is dropped.
        queue_text("T=");
        pending_chars.push_back(LF_CHAR);
        // The highest character value is invalid.
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(LF_CHAR);
        // After a padded quad CR must be followed by LF.
        queue_text("/w==");
        pending_chars.push_back(CR_CHAR);
        queue_text("A");
        pending_chars.push_back(LF_CHAR);
        wait_drained();

        // String mode, directed: a padded quad ended by NUL, CR as an invalid
        // character, and a NUL in mid quad that is both invalid and the end.
        write_mode(1'b1);
        queue_text("AA==");
        pending_chars.push_back(NUL_CHAR);
        pending_chars.push_back(CR_CHAR);
        pending_chars.push_back(NUL_CHAR);
        queue_text("TW");
        pending_chars.push_back(NUL_CHAR);
        wait_drained();

        // Random strings under alternating modes. The long receiver hold-off
        // falls inside the first of these phases.
        for (int phase_no = 0; phase_no < 4; phase_no++)
        begin
            write_mode(phase_no[0]);
            queued = 0;
            while (queued < RANDOM_ITEMS)
            begin
                queue_random_string(phase_no[0], added);
                queued += added;
            end
            wait_drained();
        end

        // A mode change in the middle of a string keeps the partial quad.
        write_mode(1'b1);
        queue_text("QUJDQQ");
        wait_drained();
        write_mode(1'b0);
        queue_text("==");
        pending_chars.push_back(CR_CHAR);
        pending_chars.push_back(LF_CHAR);
        wait_drained();

        if (fail_count == 0)
        begin
            $display("PASS base64_line_decoder");
        end
        else
        begin
            $display("FAIL base64_line_decoder");
        end
        $finish;
    end

endmodule

>>> files.f
design/b64ld_pkg.sv
design/b64ld_char_if.sv
design/b64ld_result_if.sv
design/b64ld_queue.sv
design/b64ld_front.sv
design/b64ld_back.sv
design/base64_line_decoder.sv
bench/tb_base64_line_decoder.sv
